[rtl/wyh_pkg.sv]
// wyh_pkg: shared codes and types for the wyhash_64 block.
// Holds controller op codes, operand selects, register indexes and the
// command and status structs that join the controller and the datapath.
package wyh_pkg;

    localparam int WIN_BYTES = 72;
    localparam int RECENT    = 16;
    localparam int BLOCK     = 48;
    localparam int CHUNK     = 16;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEC0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEC1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEC2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEC3 = 3'd4;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_START = 3'd2;
    localparam logic [2:0] OP_WB    = 3'd3;
    localparam logic [2:0] OP_FINIT = 3'd4;

    localparam logic [2:0] SEL_L0  = 3'd0;
    localparam logic [2:0] SEL_L1  = 3'd1;
    localparam logic [2:0] SEL_L2  = 3'd2;
    localparam logic [2:0] SEL_F16 = 3'd3;
    localparam logic [2:0] SEL_FA  = 3'd4;
    localparam logic [2:0] SEL_FB  = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] sel;
    } wyh_cmd_t;

    typedef struct packed {
        logic need_block;
        logic short_path;
        logic chunk_left;
        logic mix_done;
        logic out_busy;
    } wyh_stat_t;

endpackage

[rtl/wyh_mul.sv]
// wyh_mul: 64x64 multiply folded to 64 bits (low half xor high half).
// Uses one 32x32 multiplier over four partial products; depends on nothing.
module wyh_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        done,
    output logic [63:0] result
);

    logic [63:0]  a_reg, b_reg;
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  pp_reg;
    logic [1:0]   sh_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg, done_reg;
    logic [31:0]  x, y;

    always_comb begin
        x = cnt_reg[0] ? a_reg[63:32] : a_reg[31:0];
        y = cnt_reg[1] ? b_reg[63:32] : b_reg[31:0];
        unique case (sh_reg)
            2'd0:    acc_next = acc_reg + {64'd0, pp_reg};
            2'd1:    acc_next = acc_reg + {32'd0, pp_reg, 32'd0};
            default: acc_next = acc_reg + {pp_reg, 64'd0};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == 3'd4) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= op_a;
            b_reg   <= op_b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            pp_reg <= x * y;
            sh_reg <= {1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]};
            if (cnt_reg != 3'd0)
                acc_reg <= acc_next;
        end
    end

    assign done   = done_reg;
    assign result = acc_reg[63:0] ^ acc_reg[127:64];

endmodule

[rtl/wyh_dp.sv]
// wyh_dp: datapath of the hash block: byte window, lanes, length, config
// registers, operand selection and the output register. Uses wyh_pkg, wyh_mul.
module wyh_dp
    import wyh_pkg::*;
#(
    parameter int LENGTH_BITS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wyh_cmd_t             cmd,
    output wyh_stat_t            stat,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic [63:0]          in_word,
    input  logic [3:0]           in_count,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [63:0]          m_hash_value
);

    localparam int WIN_W = WIN_BYTES * 8;

    logic [63:0] seed_reg, sec0_reg, sec1_reg, sec2_reg, sec3_reg;
    logic [63:0] l0_reg, l1_reg, l2_reg, s_reg, t_reg, hash_reg;
    logic [WIN_W-1:0] win_reg;
    logic [5:0]  pend_reg, p_reg, i_reg;
    logic [LENGTH_BITS-1:0] len_reg;
    logic        used_reg, mvalid_reg;

    logic [63:0] seedx, op_a, op_b, av, bv, mix_res, mask, len_ext;
    logic        mix_done, start;
    logic [3:0]  cnt;
    logic [9:0]  off;
    logic [6:0]  q, n7, pa, pb;
    logic [WIN_W-1:0] wmask, wdata;

    function automatic logic [63:0] rd8(input logic [WIN_W-1:0] w, input logic [6:0] pos);
        logic [9:0] b;
        b = {pos, 3'b000};
        return w[b +: 64];
    endfunction

    function automatic logic [31:0] rd4(input logic [WIN_W-1:0] w, input logic [6:0] pos);
        logic [9:0] b;
        b = {pos, 3'b000};
        return w[b +: 32];
    endfunction

    function automatic logic [7:0] rd1(input logic [WIN_W-1:0] w, input logic [6:0] pos);
        logic [9:0] b;
        b = {pos, 3'b000};
        return w[b +: 8];
    endfunction

    assign seedx   = seed_reg ^ sec0_reg;
    assign len_ext = 64'(len_reg);
    assign n7      = {1'b0, pend_reg};
    assign q       = {2'b00, pend_reg[5:3], 2'b00};
    assign pa      = 7'({1'b0, p_reg} + {1'b0, i_reg} - 7'd16);
    assign pb      = 7'({1'b0, p_reg} + {1'b0, i_reg} - 7'd8);

    // tail words: short path reads of 1 to 16 bytes, long path overlapping read
    always_comb begin
        av = '0;
        bv = '0;
        if (!used_reg && pend_reg <= 6'd16) begin
            if (pend_reg >= 6'd4) begin
                av = {rd4(win_reg, 7'd16), rd4(win_reg, 7'd16 + q)};
                bv = {rd4(win_reg, 7'd12 + n7), rd4(win_reg, 7'd12 + n7 - q)};
            end else if (pend_reg != 6'd0) begin
                av = {40'd0, rd1(win_reg, 7'd16), rd1(win_reg, 7'd16 + {1'b0, n7[6:1]}),
                      rd1(win_reg, 7'd15 + n7)};
            end
        end else begin
            av = rd8(win_reg, pa);
            bv = rd8(win_reg, pb);
        end
    end

    always_comb begin
        unique case (cmd.sel)
            SEL_L0: begin
                op_a = rd8(win_reg, 7'd16) ^ sec1_reg;
                op_b = rd8(win_reg, 7'd24) ^ (used_reg ? l0_reg : seedx);
            end
            SEL_L1: begin
                op_a = rd8(win_reg, 7'd32) ^ sec2_reg;
                op_b = rd8(win_reg, 7'd40) ^ (used_reg ? l1_reg : seedx);
            end
            SEL_L2: begin
                op_a = rd8(win_reg, 7'd48) ^ sec3_reg;
                op_b = rd8(win_reg, 7'd56) ^ (used_reg ? l2_reg : seedx);
            end
            SEL_F16: begin
                op_a = rd8(win_reg, {1'b0, p_reg}) ^ sec1_reg;
                op_b = rd8(win_reg, {1'b0, p_reg} + 7'd8) ^ s_reg;
            end
            SEL_FA: begin
                op_a = av ^ sec1_reg;
                op_b = bv ^ s_reg;
            end
            default: begin
                op_a = sec1_reg ^ len_ext;
                op_b = t_reg;
            end
        endcase
    end

    assign start = (cmd.op == OP_START);

    wyh_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .op_a    (op_a),
        .op_b    (op_b),
        .done    (mix_done),
        .result  (mix_res)
    );

    // append: clamp the count, place bytes after the pending ones
    always_comb begin
        cnt   = (in_count > 4'd8) ? 4'd8 : in_count;
        mask  = (cnt == 4'd8) ? '1 : ((64'd1 << {cnt, 3'b000}) - 64'd1);
        off   = ({4'd0, pend_reg} + 10'd16) << 3;
        wmask = {{(WIN_W-64){1'b0}}, mask} << off;
        wdata = {{(WIN_W-64){1'b0}}, in_word & mask} << off;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg   <= '0;
            sec0_reg   <= '0;
            sec1_reg   <= '0;
            sec2_reg   <= '0;
            sec3_reg   <= '0;
            pend_reg   <= '0;
            len_reg    <= '0;
            used_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_SEED: seed_reg <= cfg_data;
                    CFG_SEC0: sec0_reg <= cfg_data;
                    CFG_SEC1: sec1_reg <= cfg_data;
                    CFG_SEC2: sec2_reg <= cfg_data;
                    CFG_SEC3: sec3_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (mvalid_reg && m_ready)
                mvalid_reg <= 1'b0;
            unique case (cmd.op)
                OP_LOAD: begin
                    win_reg  <= (win_reg & ~wmask) | wdata;
                    pend_reg <= pend_reg + {2'b00, cnt};
                    len_reg  <= len_reg + LENGTH_BITS'(cnt);
                end
                OP_FINIT: begin
                    s_reg <= used_reg ? (l0_reg ^ l1_reg ^ l2_reg) : seedx;
                    p_reg <= 6'd16;
                    i_reg <= pend_reg;
                end
                OP_WB: begin
                    unique case (cmd.sel)
                        SEL_L0: l0_reg <= mix_res;
                        SEL_L1: l1_reg <= mix_res;
                        SEL_L2: begin
                            l2_reg   <= mix_res;
                            used_reg <= 1'b1;
                            win_reg  <= win_reg >> (BLOCK * 8);
                            pend_reg <= pend_reg - 6'd48;
                        end
                        SEL_F16: begin
                            s_reg <= mix_res;
                            p_reg <= p_reg + 6'd16;
                            i_reg <= i_reg - 6'd16;
                        end
                        SEL_FA: t_reg <= mix_res;
                        default: begin
                            hash_reg   <= mix_res;
                            mvalid_reg <= 1'b1;
                            used_reg   <= 1'b0;
                            pend_reg   <= '0;
                            len_reg    <= '0;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign stat.need_block = (pend_reg > 6'd48);
    assign stat.short_path = !used_reg && (pend_reg <= 6'd16);
    assign stat.chunk_left = (i_reg > 6'd16);
    assign stat.mix_done   = mix_done;
    assign stat.out_busy   = mvalid_reg;

    assign m_valid      = mvalid_reg;
    assign m_hash_value = hash_reg;

endmodule

[rtl/wyh_ctrl.sv]
// wyh_ctrl: controller state machine of the hash block.
// Sequences word loads, 48-byte lane mixes and the final mixes; uses wyh_pkg.
module wyh_ctrl
    import wyh_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      s_last,
    input  wyh_stat_t stat,
    output wyh_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_NEXT  = 3'd4;
    localparam logic [2:0] S_FINIT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] sel_reg, sel_next;
    logic       last_reg, last_next;

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        last_next  = last_reg;
        cmd.op     = OP_NONE;
        cmd.sel    = sel_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    last_next  = s_last;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (stat.need_block) begin
                    sel_next   = SEL_L0;
                    state_next = S_START;
                end else if (last_reg) begin
                    state_next = S_FINIT;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_FINIT: begin
                cmd.op     = OP_FINIT;
                state_next = S_NEXT;
            end
            S_NEXT: begin
                sel_next   = (!stat.short_path && stat.chunk_left) ? SEL_F16 : SEL_FA;
                state_next = S_START;
            end
            S_START: begin
                cmd.op     = OP_START;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                // hold the final result until the output register is free
                if (stat.mix_done && !(sel_reg == SEL_FB && stat.out_busy)) begin
                    cmd.op = OP_WB;
                    unique case (sel_reg)
                        SEL_L0: begin
                            sel_next   = SEL_L1;
                            state_next = S_START;
                        end
                        SEL_L1: begin
                            sel_next   = SEL_L2;
                            state_next = S_START;
                        end
                        SEL_L2:  state_next = last_reg ? S_FINIT : S_IDLE;
                        SEL_F16: state_next = S_NEXT;
                        SEL_FA: begin
                            sel_next   = SEL_FB;
                            state_next = S_START;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sel_reg   <= SEL_L0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            last_reg  <= last_next;
        end
    end

endmodule

[rtl/wyhash_64.sv]
// wyhash_64: streaming 64-bit hash over little-endian message words.
// Top level; instantiates wyh_ctrl and wyh_dp, uses wyh_pkg.
//
// Input channel s_*: one beat carries up to eight bytes (s_data_word, first
// byte in bits 7:0), s_byte_count valid bytes (9..15 count as 8) and s_last.
// Output channel m_*: one beat carrying m_hash_value per message, after the
// beat marked last. Configuration: cfg_wr_en with cfg_index 0..4 writes
// hash_seed, secret_0..secret_3; other indexes are ignored. Write only idle.
// A beat that leaves 48 bytes or fewer pending is loaded and checked. One
// that brings the pending count above 48 adds three lane mixes. The last
// beat adds the final setup, then 0 to 2 16-byte mixes and the two final
// mixes. Each mix runs four partial products through the single 32x32
// multiplier, accumulating each. No new beat is taken until all are done.
// Reset clears the config registers to zero and empties the message state.
// A stalled receiver holds the hash in the output register; the next message
// is taken meanwhile and waits only at its own final write-back.
module wyhash_64
    import wyh_pkg::*;
#(
    parameter int LENGTH_BITS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [63:0]          s_data_word,
    input  logic [3:0]           s_byte_count,
    input  logic                 s_last,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [63:0]          m_hash_value
);

    wyh_cmd_t  cmd;
    wyh_stat_t stat;

    wyh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_last  (s_last),
        .stat    (stat),
        .cmd     (cmd)
    );

    wyh_dp #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_word      (s_data_word),
        .in_count     (s_byte_count),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

endmodule
